### hdl/sbq_pkg.sv
// Shared types, constants and the tanh table of the saturating biquad cascade.
`default_nettype none
package sbq_pkg;

    // Internal number formats
    localparam int SIG_W   = 36;   // section signal, Q13.23
    localparam int DLY_W   = 40;   // delay state, Q17.23
    localparam int CQ_W    = 26;   // coefficient, Q3.22
    localparam int SQ_W    = 24;   // sample, Q1.23
    localparam int ACC_W   = 64;   // accumulator
    localparam int MB_W    = 14;   // signed slice of the short operand
    localparam int SLICE_W = 13;   // bits of the short operand per pass
    localparam int PROD_W  = SIG_W + MB_W;
    localparam int NCOEF   = 5;
    localparam int TANH_SEGS = 256;
    localparam int TV_W    = 24;   // tanh table value, Q.23

    // Coefficient slots within a section
    localparam logic [2:0] COEF_B0 = 3'd0;
    localparam logic [2:0] COEF_B1 = 3'd1;
    localparam logic [2:0] COEF_B2 = 3'd2;
    localparam logic [2:0] COEF_A1 = 3'd3;
    localparam logic [2:0] COEF_A2 = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_DRIVE    = 2'd0;
    localparam logic [1:0] REG_SAT_EN   = 2'd1;
    localparam logic [1:0] REG_SAT_PRE  = 2'd2;
    localparam logic [1:0] REG_SAT_POST = 2'd3;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // Control of one pass through the shared multiply-accumulate unit
    typedef struct packed {
        logic valid;  // issue a partial product this cycle
        logic load;   // start a new sum with this partial product
        logic sub;    // subtract instead of add
        logic hi;     // upper slice of the short operand
    } mac_ctl_t;

    typedef logic [TANH_SEGS:0][TV_W-1:0] tanh_tab_t;

    // Unsigned quotient by shift and subtract, used only while building the table
    function automatic longint unsigned udiv64(longint unsigned n, longint unsigned dv);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= dv) begin
                r    = r - dv;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Build tanh(k/64) in Q.23 from the integer decay recurrence
    function automatic tanh_tab_t build_tanh();
        tanh_tab_t t;
        longint unsigned d;
        longint unsigned num;
        longint unsigned den;
        t = '0;
        d = 64'd1 << 30;
        for (int k = 1; k <= TANH_SEGS; k++) begin
            d   = (d * 64'd1040706261 + (64'd1 << 29)) >> 30;
            num = ((64'd1 << 30) - d) << 23;
            den = (64'd1 << 30) + d;
            t[k] = TV_W'(udiv64(num + (den >> 1), den));
        end
        return t;
    endfunction

    localparam tanh_tab_t TANH_TAB = build_tanh();

    // Clamp a signed value to a two's complement range of the given width
    function automatic logic signed [ACC_W-1:0] sat_w(logic signed [ACC_W-1:0] v,
                                                      int unsigned bits);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            return hi;
        else if (v < lo)
            return lo;
        return v;
    endfunction

endpackage
`default_nettype wire

### hdl/saturating_biquad_cascade.sv
// Top level: sequencer, coefficient and delay memories of the biquad cascade.
//
// Input words (s_ channel) carry either an audio sample (s_tuser = 0) or a
// coefficient write (s_tuser = 1). A coefficient word gives no output. A
// sample word runs through the drive gain and all SECTIONS transposed direct
// form II sections, one multiply slice at a time on a single shared
// multiply-accumulate unit, and yields one output word (m_ channel) with its
// channel number.
// Every product takes two passes of the shared multiplier and the accumulate
// pipeline. s_tready returns in the cycle after the output register loads.
// s_tready is high only while no sample is in work; a new sample can be taken
// while the previous output word still waits for m_tready. If the receiver
// stalls, the finished sample waits in front of the output register.
// Reset clears the configuration registers to their defaults and marks all
// coefficients and delay states as zero; there is no clearing pass.
// Configuration words must be written on cfg_wr_en only while the block is
// idle; the user is bound to this, and the block itself does not enforce it.
`default_nettype none
module saturating_biquad_cascade #(
    parameter int SECTIONS    = 6,
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 26,
    localparam int S_TDATA_W  = ((7 + SAMPLE_BITS + COEF_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((1 + SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // channel, section, coefficient_select, sample_in, coefficient_value
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // kind
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // channel_out, sample_out
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [1:0]            cfg_addr,
    input  wire logic [23:0]           cfg_wdata
);
    import sbq_pkg::*;

    localparam int CMEM_D = SECTIONS * NCOEF;
    localparam int CA_W   = $clog2(CMEM_D);
    localparam int DMEM_D = CHANNELS * SECTIONS;
    localparam int DA_W   = (DMEM_D > 1) ? $clog2(DMEM_D) : 1;
    localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DRV  = 2'd1;
    localparam logic [1:0] ST_SEC  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Steps of the sequencer within one section (and of the drive gain)
    localparam logic [4:0] SP_ADDR   = 5'd0;
    localparam logic [4:0] SP_B0_LO  = 5'd1;
    localparam logic [4:0] SP_B0_HI  = 5'd2;
    localparam logic [4:0] SP_B1_LO  = 5'd3;
    localparam logic [4:0] SP_Y      = 5'd4;   // also b1 upper slice
    localparam logic [4:0] SP_A1_LO  = 5'd5;
    localparam logic [4:0] SP_A1_HI  = 5'd6;
    localparam logic [4:0] SP_B2_LO  = 5'd7;
    localparam logic [4:0] SP_Z1     = 5'd8;   // also b2 upper slice
    localparam logic [4:0] SP_A2_LO  = 5'd9;
    localparam logic [4:0] SP_A2_HI  = 5'd10;
    localparam logic [4:0] SP_Z2     = 5'd12;  // also pre gain lower slice
    localparam logic [4:0] SP_PRE_HI = 5'd13;
    localparam logic [4:0] SP_U      = 5'd15;
    localparam logic [4:0] SP_IP_LO  = 5'd16;
    localparam logic [4:0] SP_IP_HI  = 5'd17;
    localparam logic [4:0] SP_V      = 5'd19;
    localparam logic [4:0] SP_PO_LO  = 5'd20;
    localparam logic [4:0] SP_PO_HI  = 5'd21;
    localparam logic [4:0] SP_OUT    = 5'd23;
    localparam logic [4:0] SP_DRV_X  = 5'd4;

    // Input word fields
    logic                   in_kind;
    logic                   in_ch;
    logic [2:0]             in_sec;
    logic [2:0]             in_sel;
    logic [SAMPLE_BITS-1:0] in_sample;
    logic [COEF_BITS-1:0]   in_coef;

    assign in_kind   = s_tuser;
    assign in_ch     = s_tdata[0];
    assign in_sec    = s_tdata[3:1];
    assign in_sel    = s_tdata[6:4];
    assign in_sample = s_tdata[7 +: SAMPLE_BITS];
    assign in_coef   = s_tdata[7 + SAMPLE_BITS +: COEF_BITS];

    // Control and configuration registers
    logic [1:0]       state_reg;
    logic [4:0]       step_reg;
    logic [SEC_W-1:0] sec_reg;
    logic             m_valid_reg;
    logic [23:0]      drive_reg;
    logic             sat_en_reg;
    logic [15:0]      pre_reg;
    logic [14:0]      post_reg;

    // Payload registers
    logic                    ch_reg;
    logic signed [SQ_W-1:0]  samp_reg;
    logic signed [SIG_W-1:0] x_reg;
    logic signed [SIG_W-1:0] y_reg;
    logic signed [DLY_W-1:0] z1n_reg;
    logic [7:0]              seg_reg;
    logic [16:0]             frac_reg;
    logic                    neg_reg;
    logic                    big_reg;
    logic signed [24:0]      v_reg;
    logic [M_TDATA_W-1:0]    m_data_reg;

    logic in_fire;
    logic chan_ok;
    logic sec_ok;
    logic sec_last;
    logic sec_done;
    logic out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign chan_ok  = (CHANNELS > 1) || !in_ch;
    assign sec_ok   = (32'(in_sec) < SECTIONS) && (32'(in_sel) < NCOEF);
    assign sec_last = (32'(sec_reg) == SECTIONS - 1);
    assign sec_done = (step_reg == SP_OUT) || (step_reg == SP_Z2 && !sat_en_reg);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // ---------------------------------------------------------------
    // Coefficient memory with per-entry valid bits
    logic [COEF_BITS-1:0] cmem [CMEM_D];
    logic [CMEM_D-1:0]    cvalid_reg;
    logic [COEF_BITS-1:0] crd_reg;
    logic                 crd_valid_reg;
    logic [CA_W-1:0]      cwr_addr;
    logic [CA_W-1:0]      crd_addr;
    logic [2:0]           crd_sel;
    logic                 coef_we;
    logic [CQ_W-1:0]      coef_q;
    logic [CQ_W-1:0]      coef_scaled;

    assign coef_we  = in_fire && (in_kind == KIND_COEF) && sec_ok;
    assign cwr_addr = CA_W'(32'(in_sec) * NCOEF + 32'(in_sel));
    assign crd_addr = CA_W'(32'(sec_reg) * NCOEF + 32'(crd_sel));

    // Present the address of the coefficient needed in the next step
    always_comb begin
        case (step_reg)
            SP_B0_HI, SP_B1_LO:  crd_sel = COEF_B1;
            SP_Y, SP_A1_LO:      crd_sel = COEF_A1;
            SP_A1_HI, SP_B2_LO:  crd_sel = COEF_B2;
            SP_Z1, SP_A2_LO:     crd_sel = COEF_A2;
            default:             crd_sel = COEF_B0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (coef_we)
            cmem[cwr_addr] <= in_coef;
        crd_reg <= cmem[crd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cvalid_reg    <= '0;
            crd_valid_reg <= 1'b0;
        end else begin
            if (coef_we)
                cvalid_reg[cwr_addr] <= 1'b1;
            crd_valid_reg <= cvalid_reg[crd_addr];
        end
    end

    // Move the stored coefficient to Q3.22
    generate
        if (COEF_BITS >= CQ_W) begin : g_coef_dn
            assign coef_scaled = crd_reg[COEF_BITS-1 -: CQ_W];
        end else begin : g_coef_up
            assign coef_scaled = {crd_reg, {(CQ_W - COEF_BITS){1'b0}}};
        end
    endgenerate

    assign coef_q = crd_valid_reg ? coef_scaled : '0;

    // ---------------------------------------------------------------
    // Delay state memory, one row {z1, z2} per channel and section
    logic [2*DLY_W-1:0]      dmem [DMEM_D];
    logic [DMEM_D-1:0]       dvalid_reg;
    logic [2*DLY_W-1:0]      drd_reg;
    logic                    drd_valid_reg;
    logic [DA_W-1:0]         d_addr;
    logic                    dly_we;
    logic signed [DLY_W-1:0] z1_q;
    logic signed [DLY_W-1:0] z2_q;
    logic signed [DLY_W-1:0] z2_new;

    assign d_addr = DA_W'(32'(ch_reg) * SECTIONS + 32'(sec_reg));
    assign dly_we = (state_reg == ST_SEC) && (step_reg == SP_Z2);

    always_ff @(posedge aclk) begin
        if (dly_we)
            dmem[d_addr] <= {z1n_reg, z2_new};
        drd_reg <= dmem[d_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvalid_reg    <= '0;
            drd_valid_reg <= 1'b0;
        end else begin
            if (dly_we)
                dvalid_reg[d_addr] <= 1'b1;
            drd_valid_reg <= dvalid_reg[d_addr];
        end
    end

    assign z1_q = drd_valid_reg ? signed'(drd_reg[2*DLY_W-1:DLY_W]) : '0;
    assign z2_q = drd_valid_reg ? signed'(drd_reg[DLY_W-1:0]) : '0;

    // ---------------------------------------------------------------
    // Shared multiply-accumulate unit and tanh table
    mac_ctl_t                mac_ctl;
    logic signed [SIG_W-1:0] mac_a;
    logic [CQ_W-1:0]         mac_b;
    logic signed [ACC_W-1:0] acc;
    logic [TV_W-1:0]         t_base;
    logic [TV_W-1:0]         t_slope;

    sbq_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .acc     (acc)
    );

    sbq_tanh_lut u_tanh (
        .idx       (seg_reg),
        .base_val  (t_base),
        .slope_val (t_slope)
    );

    // Operand and pass selection for each step
    always_comb begin
        mac_ctl = '0;
        mac_a   = x_reg;
        mac_b   = coef_q;
        if (state_reg == ST_DRV) begin
            mac_a = SIG_W'(samp_reg);
            mac_b = CQ_W'(drive_reg);
            case (step_reg)
                SP_B0_LO: mac_ctl = '{valid: 1'b1, load: 1'b1, sub: 1'b0, hi: 1'b0};
                SP_B0_HI: mac_ctl = '{valid: 1'b1, load: 1'b0, sub: 1'b0, hi: 1'b1};
                default:  mac_ctl = '0;
            endcase
        end else if (state_reg == ST_SEC) begin
            case (step_reg)
                SP_B0_LO, SP_B1_LO, SP_B2_LO: begin
                    mac_ctl = '{valid: 1'b1, load: 1'b1, sub: 1'b0, hi: 1'b0};
                end
                SP_B0_HI, SP_Y, SP_Z1: begin
                    mac_ctl = '{valid: 1'b1, load: 1'b0, sub: 1'b0, hi: 1'b1};
                end
                SP_A1_LO, SP_A2_LO: begin
                    mac_a   = y_reg;
                    mac_ctl = '{valid: 1'b1, load: 1'b0, sub: 1'b1, hi: 1'b0};
                end
                SP_A1_HI, SP_A2_HI: begin
                    mac_a   = y_reg;
                    mac_ctl = '{valid: 1'b1, load: 1'b0, sub: 1'b1, hi: 1'b1};
                end
                SP_Z2: begin
                    mac_a   = y_reg;
                    mac_b   = CQ_W'(pre_reg);
                    mac_ctl = '{valid: sat_en_reg, load: 1'b1, sub: 1'b0, hi: 1'b0};
                end
                SP_PRE_HI: begin
                    mac_a   = y_reg;
                    mac_b   = CQ_W'(pre_reg);
                    mac_ctl = '{valid: 1'b1, load: 1'b0, sub: 1'b0, hi: 1'b1};
                end
                SP_IP_LO, SP_IP_HI: begin
                    mac_a   = SIG_W'(t_slope);
                    mac_b   = CQ_W'(frac_reg);
                    mac_ctl = '{valid: 1'b1, load: step_reg == SP_IP_LO, sub: 1'b0,
                                hi: step_reg == SP_IP_HI};
                end
                SP_PO_LO, SP_PO_HI: begin
                    mac_a   = SIG_W'(v_reg);
                    mac_b   = CQ_W'(post_reg);
                    mac_ctl = '{valid: 1'b1, load: step_reg == SP_PO_LO, sub: 1'b0,
                                hi: step_reg == SP_PO_HI};
                end
                default: mac_ctl = '0;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Rounding, saturation and the tanh interpolation around the sum
    logic signed [ACC_W-1:0] rnd22;
    logic signed [ACC_W-1:0] rnd20;
    logic signed [ACC_W-1:0] rnd17;
    logic signed [ACC_W-1:0] rnd14;
    logic signed [ACC_W-1:0] y_new;
    logic signed [ACC_W-1:0] z1_new;
    logic signed [ACC_W-1:0] u_abs;
    logic signed [ACC_W-1:0] x_drv;
    logic signed [24:0]      v_mag;
    logic signed [SQ_W-1:0]  samp_q23;

    always_comb begin
        rnd22  = (acc + (64'sd1 <<< 21)) >>> 22;
        rnd20  = (acc + (64'sd1 <<< 19)) >>> 20;
        rnd17  = (acc + (64'sd1 <<< 16)) >>> 17;
        rnd14  = (acc + (64'sd1 <<< 13)) >>> 14;
        y_new  = sat_w(rnd22 + ACC_W'(z1_q), SIG_W);
        z1_new = sat_w(rnd22 + ACC_W'(z2_q), DLY_W);
        z2_new = DLY_W'(sat_w(rnd22, DLY_W));
        u_abs  = rnd14[ACC_W-1] ? -rnd14 : rnd14;
        x_drv  = sat_w(rnd20, SIG_W);
        if (big_reg)
            v_mag = 25'sd1 <<< 23;
        else
            v_mag = signed'({1'b0, t_base}) + 25'(rnd17);
    end

    // Move the input sample to Q1.23
    generate
        if (SAMPLE_BITS >= SQ_W) begin : g_in_dn
            assign samp_q23 = in_sample[SAMPLE_BITS-1 -: SQ_W];
        end else begin : g_in_up
            assign samp_q23 = {in_sample, {(SQ_W - SAMPLE_BITS){1'b0}}};
        end
    endgenerate

    // Move the cascade output to the sample format and clamp it
    logic signed [ACC_W-1:0]       out_wide;
    logic signed [SAMPLE_BITS-1:0] out_sample;

    generate
        if (SAMPLE_BITS >= SQ_W) begin : g_out_up
            assign out_wide = ACC_W'(x_reg) <<< (SAMPLE_BITS - SQ_W);
        end else begin : g_out_dn
            assign out_wide = ACC_W'(x_reg) >>> (SQ_W - SAMPLE_BITS);
        end
    endgenerate

    assign out_sample = SAMPLE_BITS'(sat_w(out_wide, SAMPLE_BITS));

    // ---------------------------------------------------------------
    // Sequencer and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            sec_reg     <= '0;
            m_valid_reg <= 1'b0;
            drive_reg   <= 24'd1048576;
            sat_en_reg  <= 1'b1;
            pre_reg     <= 16'd22938;
            post_reg    <= 15'd13653;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_DRIVE:    drive_reg  <= cfg_wdata;
                    REG_SAT_EN:   sat_en_reg <= cfg_wdata[0];
                    REG_SAT_PRE:  pre_reg    <= cfg_wdata[15:0];
                    REG_SAT_POST: post_reg   <= cfg_wdata[14:0];
                    default:      ;
                endcase
            end
            // raise the output word on completion, drop it once taken
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire && in_kind == KIND_SAMPLE && chan_ok) begin
                        state_reg <= ST_DRV;
                        step_reg  <= SP_B0_LO;
                        sec_reg   <= '0;
                    end
                end
                ST_DRV: begin
                    if (step_reg == SP_DRV_X) begin
                        state_reg <= ST_SEC;
                        step_reg  <= SP_ADDR;
                    end else begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_SEC: begin
                    if (sec_done) begin
                        step_reg <= SP_ADDR;
                        if (sec_last)
                            state_reg <= ST_DONE;
                        else
                            sec_reg <= sec_reg + SEC_W'(1);
                    end else begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_DONE: begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            ch_reg   <= in_ch;
            samp_reg <= samp_q23;
        end
        if (state_reg == ST_DRV && step_reg == SP_DRV_X)
            x_reg <= SIG_W'(x_drv);
        if (state_reg == ST_SEC) begin
            case (step_reg)
                SP_Y:  y_reg   <= SIG_W'(y_new);
                SP_Z1: z1n_reg <= DLY_W'(z1_new);
                SP_U: begin
                    neg_reg  <= rnd14[ACC_W-1];
                    big_reg  <= (u_abs >= (64'sd4 <<< 23));
                    seg_reg  <= u_abs[24:17];
                    frac_reg <= u_abs[16:0];
                end
                SP_V:  v_reg <= neg_reg ? -v_mag : v_mag;
                default: ;
            endcase
            // hand the section output on
            if (step_reg == SP_OUT)
                x_reg <= SIG_W'(rnd14);
            else if (step_reg == SP_Z2 && !sat_en_reg)
                x_reg <= y_reg;
        end
        if (out_load)
            m_data_reg <= M_TDATA_W'({out_sample, ch_reg});
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("output word raised outside completion");
    a_sec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEC |-> 32'(sec_reg) < SECTIONS)
        else $error("section counter out of range");
    a_sample_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_kind == KIND_SAMPLE && chan_ok |=> state_reg == ST_DRV)
        else $error("accepted sample did not start the cascade");
    a_bypass_short: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEC && !sat_en_reg |-> step_reg <= SP_Z2)
        else $error("bypassed section ran into the shaper steps");

endmodule
`default_nettype wire

### hdl/sbq_mac.sv
// Shared multiply-accumulate unit: one sliced multiply per cycle, registered product.
`default_nettype none
module sbq_mac (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire sbq_pkg::mac_ctl_t                   ctl,
    input  wire logic signed [sbq_pkg::SIG_W-1:0]    op_a,
    input  wire logic        [sbq_pkg::CQ_W-1:0]     op_b,
    output logic signed      [sbq_pkg::ACC_W-1:0]    acc
);
    import sbq_pkg::*;

    mac_ctl_t                  ctl_d_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [MB_W-1:0]    b_slice;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   base;

    // Pick the low slice unsigned or the high slice signed
    always_comb begin
        if (ctl.hi)
            b_slice = MB_W'(signed'(op_b[CQ_W-1:SLICE_W]));
        else
            b_slice = signed'({1'b0, op_b[SLICE_W-1:0]});
    end

    // Multiply stage
    always_ff @(posedge aclk) begin
        if (ctl.valid)
            prod_reg <= op_a * b_slice;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            ctl_d_reg <= '0;
        else
            ctl_d_reg <= ctl;
    end

    // Accumulate stage
    always_comb begin
        term = ACC_W'(prod_reg);
        if (ctl_d_reg.hi)
            term = term <<< SLICE_W;
        base = ctl_d_reg.load ? '0 : acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctl_d_reg.valid)
            acc_reg <= ctl_d_reg.sub ? base - term : base + term;
    end

    assign acc = acc_reg;

    a_hi_after_lo: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.valid && ctl.hi |-> $past(ctl.valid && !ctl.hi))
        else $error("upper slice issued without lower slice");
    a_hi_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.valid && ctl.hi |-> !ctl.load)
        else $error("upper slice restarts the sum");
    a_hi_same_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.valid && ctl.hi |-> ctl.sub == $past(ctl.sub))
        else $error("slices of one product differ in sign");

endmodule
`default_nettype wire

### hdl/sbq_tanh_lut.sv
// tanh segment lookup: base point and slope of one segment of the table.
`default_nettype none
module sbq_tanh_lut (
    input  wire logic [7:0]                 idx,
    output logic      [sbq_pkg::TV_W-1:0]   base_val,
    output logic      [sbq_pkg::TV_W-1:0]   slope_val
);
    import sbq_pkg::*;

    logic [TV_W-1:0] next_val;

    // Read both ends of the segment; tanh rises, so the slope is never negative
    always_comb begin
        base_val  = TANH_TAB[idx];
        next_val  = TANH_TAB[9'(idx) + 9'd1];
        slope_val = next_val - base_val;
    end

endmodule
`default_nettype wire

### tb/saturating_biquad_cascade_checker.sv
// Scoreboard for the biquad cascade: predicts each filtered word and compares it.
`default_nettype none
module saturating_biquad_cascade_checker
    import sbq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SECS = 6;
    localparam int CHS  = 2;

    typedef struct packed {
        logic        chan;
        logic [23:0] smp;
    } filtered_t;

    filtered_t   filtered_q[$];
    longint      coef_mem[SECS][NCOEF];
    longint      z1_mem[CHS][SECS];
    longint      z2_mem[CHS][SECS];
    longint      tanh_pts[TANH_SEGS + 1];
    logic [23:0] drive;
    logic        sat_on;
    logic [15:0] sat_pre;
    logic [14:0] sat_post;

    function automatic longint fshr(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint rshr(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(longint x, int bits);
        longint hi;
        hi = (longint'(1) << (bits - 1)) - 1;
        return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
    endfunction

    // Integer tanh table, built the same way the block is specified
    function automatic void fill_tanh();
        longint unsigned d;
        longint unsigned num;
        longint unsigned den;
        d = 64'd1 << 30;
        tanh_pts[0] = 0;
        for (int k = 1; k <= TANH_SEGS; k++) begin
            d = (d * 64'd1040706261 + (64'd1 << 29)) >> 30;
            num = ((64'd1 << 30) - d) << 23;
            den = (64'd1 << 30) + d;
            tanh_pts[k] = longint'((num + den / 2) / den);
        end
    endfunction

    function automatic longint soft_clip(longint y);
        longint u;
        longint a;
        longint v;
        longint i;
        u = rshr(y * longint'(sat_pre), 14);
        a = u < 0 ? -u : u;
        if (a >= (longint'(4) << 23)) begin
            v = longint'(1) << 23;
        end else begin
            i = a >>> 17;
            v = tanh_pts[i] + rshr((tanh_pts[i + 1] - tanh_pts[i]) * (a & 'h1FFFF), 17);
        end
        if (u < 0) v = -v;
        return rshr(v * longint'(sat_post), 14);
    endfunction

    // Run one sample through the cascade and update that channel's delays
    function automatic filtered_t filter_sample(logic ch, logic signed [23:0] s);
        longint x;
        longint y;
        filtered_t r;
        x = clamp(rshr(longint'(s) * longint'(drive), 20), SIG_W);
        for (int k = 0; k < SECS; k++) begin
            y = clamp(rshr(coef_mem[k][COEF_B0] * x, 22) + z1_mem[ch][k], SIG_W);
            z1_mem[ch][k] = clamp(rshr(coef_mem[k][COEF_B1] * x - coef_mem[k][COEF_A1] * y, 22)
                                  + z2_mem[ch][k], DLY_W);
            z2_mem[ch][k] = clamp(rshr(coef_mem[k][COEF_B2] * x - coef_mem[k][COEF_A2] * y, 22),
                                  DLY_W);
            if (sat_on) y = soft_clip(y);
            x = y;
        end
        r.chan = ch;
        r.smp  = 24'(clamp(x, 24));
        return r;
    endfunction

    assign pending = filtered_q.size();

    always @(posedge aclk) begin
        filtered_t got;
        filtered_t want;
        if (!aresetn) begin
            drive = 24'd1048576;
            sat_on = 1'b1;
            sat_pre = 16'd22938;
            sat_post = 15'd13653;
            foreach (coef_mem[i, j]) coef_mem[i][j] = 0;
            foreach (z1_mem[i, j]) begin
                z1_mem[i][j] = 0;
                z2_mem[i][j] = 0;
            end
            fill_tanh();
            filtered_q.delete();
            fail_count <= 0;
        end else begin
            // Register writes
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_DRIVE:    drive = cfg_wdata;
                    REG_SAT_EN:   sat_on = cfg_wdata[0];
                    REG_SAT_PRE:  sat_pre = cfg_wdata[15:0];
                    REG_SAT_POST: sat_post = cfg_wdata[14:0];
                    default: ;
                endcase
            end
            // Check the output word against the oldest prediction
            if (m_tvalid && m_tready) begin
                got = filtered_t'({m_tdata[0], m_tdata[24:1]});
                if (filtered_q.size() == 0) begin
                    $display("%0t: unexpected word, actual ch=%0d smp=%h",
                             $time, got.chan, got.smp);
                    fail_count <= fail_count + 1;
                end else begin
                    want = filtered_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected ch=%0d smp=%h actual ch=%0d smp=%h",
                                 $time, want.chan, want.smp, got.chan, got.smp);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // Input word: coefficient write or sample
            if (s_tvalid && s_tready) begin
                if (s_tuser == KIND_COEF) begin
                    if (s_tdata[3:1] < SECS && s_tdata[6:4] < NCOEF)
                        coef_mem[s_tdata[3:1]][s_tdata[6:4]] =
                            longint'($signed(s_tdata[56:31]));
                end else begin
                    filtered_q.push_back(filter_sample(s_tdata[0], s_tdata[30:7]));
                end
            end
        end
    end
endmodule
`default_nettype wire

### tb/saturating_biquad_cascade_tb.sv
// Stimulus and verdict for the biquad cascade.
`default_nettype none
module saturating_biquad_cascade_tb;
    import sbq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [23:0] cfg_wdata = '0;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    bit          long_stall_done = 1'b0;

    always #4 aclk = ~aclk;

    saturating_biquad_cascade dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .cfg_wr_en, .cfg_addr, .cfg_wdata
    );

    saturating_biquad_cascade_checker chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .cfg_wr_en, .cfg_addr, .cfg_wdata,
        .fail_count, .pending
    );

    // Send one word, holding it until accepted; valid stays up for the next one
    task automatic send_word(logic kind, logic [63:0] data);
        s_tuser  <= kind;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic put_sample(logic ch, logic [23:0] smp);
        send_word(KIND_SAMPLE, {7'b0, 26'($urandom), smp, 6'($urandom), ch});
    endtask

    task automatic put_coef(logic [2:0] sec, logic [2:0] sel, logic [25:0] val);
        send_word(KIND_COEF, {7'b0, val, 24'($urandom), sel, sec, 1'($urandom)});
    endtask

    // Write one register; the enable stays up for a following write
    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Wait for every prediction to drain, then let the datapath settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // Mild filter: b0 near one, small feedback, random small extras; all random if wild
    task automatic load_filter(bit wild);
        for (int k = 0; k < 6; k++) begin
            put_coef(3'(k), COEF_B0, wild ? 26'($urandom) : 26'(4194304 - $urandom_range(0, 2000000)));
            put_coef(3'(k), COEF_B1, wild ? 26'($urandom) : 26'($signed($urandom_range(0, 2000000)) - 1000000));
            put_coef(3'(k), COEF_B2, wild ? 26'($urandom) : 26'($signed($urandom_range(0, 1000000)) - 500000));
            put_coef(3'(k), COEF_A1, wild ? 26'($urandom) : 26'($signed($urandom_range(0, 2000000)) - 1000000));
            put_coef(3'(k), COEF_A2, wild ? 26'($urandom) : 26'($urandom_range(0, 1500000)));
        end
    endtask

    // Receiver: stall pattern plus a long hold-off when asked
    always @(posedge aclk) begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 7) < 5) || ($urandom_range(0, 3) == 0);
    end

    // Watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("saturating_biquad_cascade_tb failed");
            $finish;
        end
    end

    initial begin
        int gap;
        int burst;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: sample with zero coefficients, extremes, ignored writes
        put_sample(1'b0, 24'h7FFFFF);
        for (int k = 0; k < 6; k++) put_coef(3'(k), COEF_B0, 26'd4194304);
        put_sample(1'b0, 24'h7FFFFF);
        put_sample(1'b1, 24'h800000);
        put_sample(1'b0, 24'h000000);
        put_coef(3'd6, COEF_B0, 26'h3FFFFFF);
        put_coef(3'd7, COEF_A2, 26'h2000000);
        put_coef(3'd0, 3'd5, 26'h1FFFFFF);
        put_coef(3'd1, 3'd7, 26'h2000000);
        put_sample(1'b1, 24'h7FFFFF);
        put_coef(3'd5, COEF_B0, 26'h1FFFFFF);
        put_coef(3'd5, COEF_A1, 26'h2000000);
        put_sample(1'b0, 24'h800000);
        put_sample(1'b1, 24'h000001);
        put_sample(1'b0, 24'hFFFFFF);
        drain();

        // Phases through register settings, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin write_reg(REG_DRIVE, 24'hFFFFFF); write_reg(REG_SAT_EN, 24'd0); end
                1: begin write_reg(REG_DRIVE, 24'd0); write_reg(REG_SAT_EN, 24'hFFFFFF); end
                2: begin write_reg(REG_SAT_PRE, 24'd16384); write_reg(REG_SAT_POST, 24'd16384); end
                3: begin write_reg(REG_SAT_PRE, 24'd49152); write_reg(REG_SAT_POST, 24'd8192);
                         write_reg(REG_DRIVE, 24'd1048576); end
                4: begin write_reg(REG_SAT_EN, 24'd0); write_reg(REG_DRIVE, 24'($urandom)); end
                default: begin
                    write_reg(REG_DRIVE, 24'($urandom_range(0, 4000000)));
                    write_reg(REG_SAT_EN, 24'($urandom));
                    write_reg(REG_SAT_PRE, 24'($urandom_range(16384, 49152)));
                    write_reg(REG_SAT_POST, 24'($urandom_range(8192, 16384)));
                end
            endcase
            cfg_wr_en <= 1'b0;
            load_filter(ph == 4);
            for (int n = 0; n < 130; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 130; b++, n++) begin
                    if ($urandom_range(0, 19) == 0)
                        put_coef(3'($urandom), 3'($urandom), 26'($urandom));
                    else
                        put_sample(1'($urandom), 24'($urandom));
                end
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                // Long receiver hold-off once, while words keep coming
                if (ph == 2 && !long_stall_done && n > 40) begin
                    long_stall_done = 1'b1;
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (3000) @(posedge aclk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("saturating_biquad_cascade_tb passed");
        else
            $display("saturating_biquad_cascade_tb failed");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
hdl/sbq_pkg.sv
hdl/sbq_mac.sv
hdl/sbq_tanh_lut.sv
hdl/saturating_biquad_cascade.sv
tb/saturating_biquad_cascade_checker.sv
tb/saturating_biquad_cascade_tb.sv
